### src/fcpt_pkg.sv
// ----------------------------------------------------------------------------
// fcpt_pkg: shared types and constants of the function call profiler table
// Holds the table geometry, request and status codes, and the queue record
// that passes classified requests from the front end to the back end.
// ----------------------------------------------------------------------------
package fcpt_pkg;

    localparam int unsigned Entries  = 4096;
    localparam int unsigned IdxW     = $clog2(Entries);
    localparam int unsigned OutIdxW  = 12;
    localparam int unsigned MeanW    = 48;
    localparam int unsigned CountW   = 32;
    localparam int unsigned LevelW   = 8;
    localparam int unsigned StampW   = 64;
    localparam int unsigned DivW     = 128;

    // request codes
    localparam logic [1:0] ReqEnter = 2'd0;
    localparam logic [1:0] ReqExit  = 2'd1;

    // status codes
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_RANGE    = 2'd1,
        ST_UNMATCH  = 2'd2,
        ST_DISABLED = 2'd3
    } t_status;

    // operation decided by the front end
    typedef enum logic [1:0] {
        OP_READ  = 2'd0,
        OP_ENTER = 2'd1,
        OP_EXIT  = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    // classified request between front and back end
    typedef struct packed {
        t_op               op;
        logic              in_range;
        t_status           status;
        logic [IdxW-1:0]   idx;
        logic [StampW-1:0] stamp;
        logic [31:0]       calib;
    } t_req;

    // back end sequencer states
    typedef enum logic [3:0] {
        BS_IDLE,
        BS_CLEAR,
        BS_READ,
        BS_DECIDE,
        BS_MUL0,
        BS_MUL1,
        BS_DIV,
        BS_WRITE,
        BS_OUT
    } t_bstate;

endpackage

### src/fcpt_front.sv
// ----------------------------------------------------------------------------
// fcpt_front: request intake and classification
// Forms the table index, checks enable and range, and pushes a classified
// request into a two-entry queue toward the back end.
// ----------------------------------------------------------------------------
module fcpt_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [1:0]            i_req_type,
    input  logic [63:0]           i_func_addr,
    input  logic [63:0]           i_cycle_stamp,
    input  logic                  i_enable,
    input  logic [63:0]           i_text_base,
    input  logic [31:0]           i_calib,
    output logic                  o_q_valid,
    input  logic                  i_q_pop,
    output fcpt_pkg::t_req        o_q_data
);

    fcpt_pkg::t_req r_q [2];
    logic           r_rd_ptr;
    logic           r_wr_ptr;
    logic [1:0]     r_cnt;
    logic [63:0]    w_diff;
    fcpt_pkg::t_req w_req;
    logic           w_push;

    // classify the incoming request
    always_comb begin
        w_diff         = i_func_addr - i_text_base;
        w_req.idx      = w_diff[fcpt_pkg::IdxW-1:0];
        w_req.stamp    = i_cycle_stamp;
        w_req.calib    = i_calib;
        w_req.in_range = (w_diff < 64'(fcpt_pkg::Entries));
        w_req.status   = fcpt_pkg::ST_OK;
        w_req.op       = fcpt_pkg::OP_READ;
        if ((i_req_type == fcpt_pkg::ReqEnter || i_req_type == fcpt_pkg::ReqExit)
                && !i_enable) begin
            w_req.status = fcpt_pkg::ST_DISABLED;
            w_req.op     = fcpt_pkg::OP_NONE;
        end else if (!w_req.in_range) begin
            w_req.status = fcpt_pkg::ST_RANGE;
            w_req.op     = fcpt_pkg::OP_NONE;
        end else if (i_req_type == fcpt_pkg::ReqEnter) begin
            w_req.op = fcpt_pkg::OP_ENTER;
        end else if (i_req_type == fcpt_pkg::ReqExit) begin
            w_req.op = fcpt_pkg::OP_EXIT;
        end
    end

    assign o_ready   = (r_cnt != 2'd2);
    assign w_push    = i_valid && o_ready;
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_data  = r_q[r_rd_ptr];

    // queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_ptr <= 1'b0;
            r_wr_ptr <= 1'b0;
            r_cnt    <= 2'd0;
        end else begin
            if (w_push) r_wr_ptr <= ~r_wr_ptr;
            if (i_q_pop) r_rd_ptr <= ~r_rd_ptr;
            r_cnt <= r_cnt + 2'(w_push) - 2'(i_q_pop);
        end
    end

    // queue storage
    always_ff @(posedge i_clk) begin
        if (w_push) r_q[r_wr_ptr] <= w_req;
    end

endmodule

### src/fcpt_div.sv
// ----------------------------------------------------------------------------
// fcpt_div: radix-2 restoring divider
// Divides a 128-bit dividend by a 33-bit divisor, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module fcpt_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [fcpt_pkg::DivW-1:0]   i_dividend,
    input  logic [32:0]                 i_divisor,
    output logic                        o_done,
    output logic [fcpt_pkg::DivW-1:0]   o_quot
);

    logic [fcpt_pkg::DivW-1:0] r_quot;
    logic [33:0]               r_rem;
    logic [32:0]               r_dsr;
    logic [7:0]                r_cnt;
    logic                      r_busy;
    logic [33:0]               w_sh;
    logic [34:0]               w_sub;

    assign w_sh   = {r_rem[32:0], r_quot[fcpt_pkg::DivW-1]};
    assign w_sub  = {1'b0, w_sh} - {2'b0, r_dsr};
    assign o_quot = r_quot;

    // one shift-subtract step per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 8'(fcpt_pkg::DivW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 8'd1;
                if (r_cnt == 8'd1) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quot <= i_dividend;
            r_rem  <= '0;
            r_dsr  <= i_divisor;
        end else if (r_busy) begin
            if (!w_sub[34]) begin
                r_rem  <= w_sub[33:0];
                r_quot <= {r_quot[fcpt_pkg::DivW-2:0], 1'b1};
            end else begin
                r_rem  <= w_sh;
                r_quot <= {r_quot[fcpt_pkg::DivW-2:0], 1'b0};
            end
        end
    end

endmodule

### src/fcpt_back.sv
// ----------------------------------------------------------------------------
// fcpt_back: table update sequencer
// Reads the entry, updates level, stamp, count and mean, writes it back and
// presents the result in an output register.
// ----------------------------------------------------------------------------
module fcpt_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_q_valid,
    output logic                  o_q_pop,
    input  fcpt_pkg::t_req        i_q_data,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [11:0]           o_entry_index,
    output logic [31:0]           o_hit_count,
    output logic [47:0]           o_mean_cycles,
    output logic [7:0]            o_nest_level,
    output logic [1:0]            o_status
);

    localparam int unsigned IdxW = fcpt_pkg::IdxW;
    localparam int unsigned RowW = fcpt_pkg::MeanW + fcpt_pkg::CountW + fcpt_pkg::LevelW;

    // memories
    logic [RowW-1:0]               r_row_mem   [fcpt_pkg::Entries];
    logic [fcpt_pkg::StampW-1:0]   r_stamp_mem [fcpt_pkg::Entries];

    fcpt_pkg::t_bstate r_state, n_state;
    fcpt_pkg::t_req    r_req;
    logic [RowW-1:0]   r_row;
    logic [63:0]       r_start;
    logic [IdxW:0]     r_clr;
    logic [47:0]       r_mean;
    logic [31:0]       r_count;
    logic [7:0]        r_level;
    logic [63:0]       r_x;
    logic [63:0]       r_p0;
    logic [63:0]       r_p1;

    logic              w_div_start;
    logic              w_div_done;
    logic [127:0]      w_quot;
    logic              w_wr;
    logic [RowW-1:0]   w_wr_row;
    logic [IdxW-1:0]   w_wr_addr;
    logic [63:0]       w_x;
    logic [127:0]      w_t;
    logic              w_fold;

    fcpt_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_t),
        .i_divisor  ({1'b0, r_count} + 33'd1),
        .o_done     (w_div_done),
        .o_quot     (w_quot)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            fcpt_pkg::BS_CLEAR:  if (r_clr[IdxW]) n_state = fcpt_pkg::BS_IDLE;
            fcpt_pkg::BS_IDLE:   if (i_q_valid) n_state = fcpt_pkg::BS_READ;
            fcpt_pkg::BS_READ:   n_state = fcpt_pkg::BS_DECIDE;
            fcpt_pkg::BS_DECIDE: n_state = w_fold ? fcpt_pkg::BS_MUL0 : fcpt_pkg::BS_WRITE;
            fcpt_pkg::BS_MUL0:   n_state = fcpt_pkg::BS_MUL1;
            fcpt_pkg::BS_MUL1:   n_state = fcpt_pkg::BS_DIV;
            fcpt_pkg::BS_DIV:    if (w_div_done) n_state = fcpt_pkg::BS_WRITE;
            fcpt_pkg::BS_WRITE:  n_state = fcpt_pkg::BS_OUT;
            fcpt_pkg::BS_OUT:    if (!o_valid || i_ready) n_state = fcpt_pkg::BS_IDLE;
            default:             n_state = fcpt_pkg::BS_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        o_q_pop     = (r_state == fcpt_pkg::BS_IDLE) && i_q_valid;
        w_div_start = (r_state == fcpt_pkg::BS_MUL1);
        w_wr        = (r_state == fcpt_pkg::BS_CLEAR) || (r_state == fcpt_pkg::BS_WRITE);
        w_wr_addr   = (r_state == fcpt_pkg::BS_CLEAR) ? r_clr[IdxW-1:0] : r_req.idx;
        w_wr_row    = (r_state == fcpt_pkg::BS_CLEAR) ? '0 : {r_mean, r_count, r_level};
        w_x         = (r_req.stamp - r_start) - {32'd0, r_req.calib};
        // outermost exit with a positive calibrated interval
        w_fold      = (r_req.op == fcpt_pkg::OP_EXIT) && (r_level == 8'd1) &&
                      (w_x != 64'd0) && !w_x[63];
        // dividend mean*count + x, ready when the divider starts
        w_t         = {64'd0, r_p0} + {32'd0, r_p1, 32'd0} + {64'd0, r_x};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fcpt_pkg::BS_CLEAR;
            r_clr   <= '0;
            o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == fcpt_pkg::BS_CLEAR) r_clr <= r_clr + 1'b1;
            if (r_state == fcpt_pkg::BS_OUT && (!o_valid || i_ready)) begin
                o_valid <= 1'b1;
            end else if (o_valid && i_ready) begin
                o_valid <= 1'b0;
            end
        end
    end

    // table memories
    always_ff @(posedge i_clk) begin
        if (w_wr) r_row_mem[w_wr_addr] <= w_wr_row;
        if (r_state == fcpt_pkg::BS_WRITE && r_req.op == fcpt_pkg::OP_ENTER && r_row[7:0] == 8'd0)
            r_stamp_mem[r_req.idx] <= r_req.stamp;
        if (r_state == fcpt_pkg::BS_IDLE) begin
            r_row   <= r_row_mem[i_q_data.idx];
            r_start <= r_stamp_mem[i_q_data.idx];
        end
    end

    // entry update datapath
    always_ff @(posedge i_clk) begin
        if (o_q_pop) r_req <= i_q_data;
        unique case (r_state)
            fcpt_pkg::BS_READ: begin
                {r_mean, r_count, r_level} <= r_row;
            end
            fcpt_pkg::BS_DECIDE: begin
                r_x <= w_x;
                if (r_req.op == fcpt_pkg::OP_ENTER) begin
                    if (r_level != 8'hFF) r_level <= r_level + 8'd1;
                end else if (r_req.op == fcpt_pkg::OP_EXIT) begin
                    if (r_level == 8'd0) begin
                        r_req.status <= fcpt_pkg::ST_UNMATCH;
                    end else begin
                        r_level <= r_level - 8'd1;
                        if (r_level == 8'd1 && !w_fold && r_count != 32'hFFFF_FFFF)
                            r_count <= r_count + 32'd1;
                    end
                end
            end
            fcpt_pkg::BS_MUL0: begin
                r_p0 <= {32'd0, r_mean[31:0]} * {32'd0, r_count};
                r_p1 <= {48'd0, r_mean[47:32]} * {32'd0, r_count};
            end
            fcpt_pkg::BS_DIV: begin
                if (w_div_done) begin
                    r_mean <= (w_quot[127:48] != 80'd0) ? 48'hFFFF_FFFF_FFFF : w_quot[47:0];
                    if (r_count != 32'hFFFF_FFFF) r_count <= r_count + 32'd1;
                end
            end
            default: ;
        endcase
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (r_state == fcpt_pkg::BS_OUT && (!o_valid || i_ready)) begin
            o_status <= r_req.status;
            if (r_req.in_range) begin
                o_entry_index <= 12'(r_req.idx);
                o_hit_count   <= r_count;
                o_mean_cycles <= r_mean;
                o_nest_level  <= r_level;
            end else begin
                o_entry_index <= '0;
                o_hit_count   <= '0;
                o_mean_cycles <= '0;
                o_nest_level  <= '0;
            end
        end
    end

endmodule

### src/function_call_profiler_table_top.sv
// ----------------------------------------------------------------------------
// function_call_profiler_table_top: per-function call profiling table
// Tracks nesting, call counts and mean call durations per function entry.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid/o_ready) takes one request: enter, exit or read of
//   the entry at i_func_addr minus text_base. Output channel (o_valid/i_ready)
//   returns one result per request with the entry after the event and status.
//   APB registers: 0x00 enable, 0x08 text_base, 0x10 calibration_cycles.
//   Sequencing: reads, enters and non-final exits pass the sequencer states
//   IDLE, READ, DECIDE, WRITE and OUT; an exit that folds a positive interval
//   into the mean also passes MUL0, MUL1 and DIV, where it waits on the
//   128-step serial divider of (mean*count+x)/(count+1).
//   A two-entry queue decouples intake from the table sequencer, so requests
//   are taken while a result waits on a stalled receiver.
//   After reset the sequencer clears the table, one entry a cycle; the queue
//   still accepts up to two requests meanwhile.
//   A stalled receiver holds the result register and the table sequencer.
// ----------------------------------------------------------------------------
module function_call_profiler_table_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_req_type,
    input  logic [63:0] i_func_addr,
    input  logic [63:0] i_cycle_stamp,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [11:0] o_entry_index,
    output logic [31:0] o_hit_count,
    output logic [47:0] o_mean_cycles,
    output logic [7:0]  o_nest_level,
    output logic [1:0]  o_status,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

    localparam logic [1:0] RegEnable = 2'd0;
    localparam logic [1:0] RegBase   = 2'd1;
    localparam logic [1:0] RegCalib  = 2'd2;

    logic           r_enable;
    logic [63:0]    r_text_base;
    logic [31:0]    r_calib;
    logic           w_q_valid;
    logic           w_q_pop;
    fcpt_pkg::t_req w_q_data;
    logic [1:0]     w_reg;

    assign pready = 1'b1;
    assign w_reg  = paddr[4:3];

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable    <= 1'b0;
            r_text_base <= '0;
            r_calib     <= '0;
        end else if (psel && penable && pwrite && paddr[2:0] == 3'd0) begin
            if (w_reg == RegEnable) r_enable <= pwdata[0];
            if (w_reg == RegBase)   r_text_base <= pwdata;
            if (w_reg == RegCalib)  r_calib <= pwdata[31:0];
        end
    end

    // register read-back
    always_comb begin
        prdata = '0;
        if (paddr[2:0] == 3'd0) begin
            if (w_reg == RegEnable) prdata = {63'd0, r_enable};
            if (w_reg == RegBase)   prdata = r_text_base;
            if (w_reg == RegCalib)  prdata = {32'd0, r_calib};
        end
    end

    fcpt_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_req_type    (i_req_type),
        .i_func_addr   (i_func_addr),
        .i_cycle_stamp (i_cycle_stamp),
        .i_enable      (r_enable),
        .i_text_base   (r_text_base),
        .i_calib       (r_calib),
        .o_q_valid     (w_q_valid),
        .i_q_pop       (w_q_pop),
        .o_q_data      (w_q_data)
    );

    fcpt_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (w_q_valid),
        .o_q_pop       (w_q_pop),
        .i_q_data      (w_q_data),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_entry_index (o_entry_index),
        .o_hit_count   (o_hit_count),
        .o_mean_cycles (o_mean_cycles),
        .o_nest_level  (o_nest_level),
        .o_status      (o_status)
    );

endmodule
